// ===== sv/depth_iqm_kalman_filter_macros.svh =====
// Assertion helpers for the depth filter checker.
`ifndef DEPTH_IQM_KALMAN_FILTER_MACROS_SVH
`define DEPTH_IQM_KALMAN_FILTER_MACROS_SVH

// Check on every clock edge outside reset.
`define DIKF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define DIKF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/dikf_pkg.sv =====
package dikf_pkg;

  localparam int RingDepth = 16;
  localparam int DivNumW   = 48;
  localparam int DivDenW   = 33;

  localparam logic [31:0] CovReset   = 32'd65536000;
  localparam logic [31:0] QReset     = 32'd655;
  localparam logic [31:0] RReset     = 32'd327680;
  localparam logic [15:0] ScaleReset = 16'd410;
  localparam logic [15:0] RangeReset = 16'd56000;
  localparam logic [15:0] DivLReset  = 16'd32000;

  typedef enum logic [2:0] {
    CFG_Q     = 3'd0,
    CFG_R     = 3'd1,
    CFG_SCALE = 3'd2,
    CFG_RANGE = 3'd3,
    CFG_DIVL  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_SHIFT
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       odd;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT,
    ST_SUM,
    ST_MDIV,
    ST_WAIT,
    ST_UPD1,
    ST_UPD2,
    ST_UPD3,
    ST_SCALE,
    ST_OUT
  } state_e;

endpackage

// ===== sv/dikf_cell.sv =====
module dikf_cell import dikf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctl_t   ctl_i,
  input  logic        pair_right_i,
  input  logic        pair_left_i,
  input  logic [15:0] load_val_i,
  input  logic        load_vld_i,
  input  logic [15:0] left_val_i,
  input  logic        left_vld_i,
  input  logic [15:0] right_val_i,
  input  logic        right_vld_i,
  output logic [15:0] val_o,
  output logic        vld_o
);

  logic [15:0] val_q, val_d;
  logic        vld_q, vld_d;

  // Empty entries sort above every sample.
  function automatic logic above(logic av, logic [15:0] a, logic bv, logic [15:0] b);
    return (!av && bv) || ((av == bv) && (a > b));
  endfunction

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    case (ctl_i.mode)
      CELL_LOAD: begin
        val_d = load_val_i;
        vld_d = load_vld_i;
      end
      CELL_SORT: begin
        if (pair_right_i && above(vld_q, val_q, right_vld_i, right_val_i)) begin
          val_d = right_val_i;
          vld_d = right_vld_i;
        end else if (pair_left_i && above(left_vld_i, left_val_i, vld_q, val_q)) begin
          val_d = left_val_i;
          vld_d = left_vld_i;
        end
      end
      CELL_SHIFT: begin
        val_d = right_val_i;
        vld_d = right_vld_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

// ===== sv/dikf_div.sv =====
module dikf_div import dikf_pkg::*; #(
  parameter int NUM_W = DivNumW,
  parameter int DEN_W = DivDenW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [CntW-1:0]  cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   rem_sh, rem_sub;

  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // One quotient bit per cycle, restoring.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sub[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

endmodule

// ===== sv/depth_iqm_kalman_filter.sv =====
// An accepted sample runs LOAD, SORT, SUM, MDIV, WAIT, UPD1-3, SCALE and OUT before its result;
// a rejected sample goes from IDLE straight to SCALE and OUT. One item at a time: the next
// sample is taken only after the result has left OUT and the block is back in IDLE, and an
// output stall holds it in OUT.
// The sort chain (RING_DEPTH odd-even passes, then a shift-out that sums the middle entries)
// and the 48-step serial divider for the mean make up most of an accepted sample's work.
// Reset (async, active low) empties the ring, zeroes the estimate, sets covariance to
// 1000.0 and loads register defaults; no clearing pass.
module depth_iqm_kalman_filter import dikf_pkg::*; #(
  parameter int RING_DEPTH = RingDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] raw_depth_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] depth_out_o,
  output logic        accepted_o,
  output logic        was_reset_o
);

  localparam int FillW = $clog2(RING_DEPTH + 1);
  localparam int SumW  = 16 + FillW;

  state_e state_q, state_d;

  logic [31:0] q_q, r_q;
  logic [15:0] scale_q, range_q, divl_q;

  logic [15:0]      ring_q [RING_DEPTH];
  logic [FillW-1:0] fill_q;
  logic [23:0]      est_q;
  logic [31:0]      cov_q, p_q;
  logic [FillW-1:0] cnt_q;
  logic [SumW-1:0]  sum_q;
  logic [16:0]      k_q;
  logic [23:0]      mean_q;
  logic             up_q;
  logic [40:0]      prod_q;
  logic [48:0]      cprod_q;
  logic [39:0]      sprod_q;
  logic             acc_q, wr_q;
  logic             ov_q;
  logic [15:0]      dout_q;
  logic             oacc_q, owr_q;

  logic             in_acc, reject, diverge, cnt_last, out_free;
  logic [23:0]      rawq, gap, divl_sh;
  logic [31:0]      cov_eff;
  logic [32:0]      p_sum, den;
  logic [FillW+1:0] tri3;
  logic [FillW-1:0] lo, hi, iq_cnt;
  logic [24:0]      mag;
  logic [19:0]      sshift;

  cell_ctl_t        cell_ctl;
  logic [15:0]      cval [RING_DEPTH];
  logic             cvld [RING_DEPTH];

  logic             gdiv_start, gdiv_busy, mdiv_start, mdiv_busy;
  logic [DivNumW-1:0] gquo, mquo, mnum;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign reject     = (raw_depth_i == 16'd0) || (raw_depth_i > range_q);
  assign rawq       = {raw_depth_i, 8'd0};
  assign gap        = (rawq > est_q) ? rawq - est_q : est_q - rawq;
  assign divl_sh    = {divl_q, 8'd0};
  assign diverge    = (est_q != 24'd0) && (gap > divl_sh);
  assign cov_eff    = diverge ? CovReset : cov_q;
  assign p_sum      = {1'b0, cov_eff} + {1'b0, q_q};
  assign den        = {1'b0, p_q} + {1'b0, r_q};
  assign cnt_last   = (cnt_q == FillW'(RING_DEPTH - 1));
  assign out_free   = !ov_q || !out_stall_i;

  assign tri3   = {2'b00, fill_q} + {1'b0, fill_q, 1'b0};
  assign lo     = fill_q >> 2;
  assign hi     = tri3[FillW+1:2];
  assign iq_cnt = hi - lo + 1'b1;
  assign mnum   = DivNumW'({sum_q, 8'd0}) + DivNumW'(iq_cnt >> 1);

  assign mag    = 25'((prod_q + 41'd32768) >> 16);
  assign sshift = 20'((sprod_q + 40'd524288) >> 20);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = reject ? ST_SCALE : ST_LOAD;
      ST_LOAD:  state_d = ST_SORT;
      ST_SORT:  if (cnt_last) state_d = ST_SUM;
      ST_SUM:   if (cnt_last) state_d = ST_MDIV;
      ST_MDIV:  state_d = ST_WAIT;
      ST_WAIT:  if (!mdiv_busy && !gdiv_busy) state_d = ST_UPD1;
      ST_UPD1:  state_d = ST_UPD2;
      ST_UPD2:  state_d = ST_UPD3;
      ST_UPD3:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    cell_ctl.mode = CELL_HOLD;
    cell_ctl.odd  = cnt_q[0];
    gdiv_start    = 1'b0;
    mdiv_start    = 1'b0;
    case (state_q)
      ST_LOAD: begin
        cell_ctl.mode = CELL_LOAD;
        gdiv_start    = 1'b1;
      end
      ST_SORT: cell_ctl.mode = CELL_SORT;
      ST_SUM:  cell_ctl.mode = CELL_SHIFT;
      ST_MDIV: mdiv_start = 1'b1;
      default: ;
    endcase
  end

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    logic        pr, pl, lvld, rvld;
    logic [15:0] lval, rval;
    assign pr   = ((i % 2) == 32'(cell_ctl.odd)) && (i + 1 < RING_DEPTH);
    assign pl   = ((i % 2) != 32'(cell_ctl.odd)) && (i > 0);
    if (i > 0) begin : g_l
      assign lval = cval[i-1];
      assign lvld = cvld[i-1];
    end else begin : g_l0
      assign lval = '0;
      assign lvld = 1'b0;
    end
    if (i + 1 < RING_DEPTH) begin : g_r
      assign rval = cval[i+1];
      assign rvld = cvld[i+1];
    end else begin : g_rn
      assign rval = '0;
      assign rvld = 1'b0;
    end
    dikf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl),
      .pair_right_i (pr),
      .pair_left_i  (pl),
      .load_val_i   (ring_q[i]),
      .load_vld_i   (FillW'(i) < fill_q),
      .left_val_i   (lval),
      .left_vld_i   (lvld),
      .right_val_i  (rval),
      .right_vld_i  (rvld),
      .val_o        (cval[i]),
      .vld_o        (cvld[i])
    );
  end

  dikf_div u_gdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gdiv_start),
    .num_i   ({p_q, 16'd0}),
    .den_i   (den),
    .busy_o  (gdiv_busy),
    .quo_o   (gquo)
  );

  dikf_div u_mdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mdiv_start),
    .num_i   (mnum),
    .den_i   (DivDenW'(iq_cnt)),
    .busy_o  (mdiv_busy),
    .quo_o   (mquo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q     <= QReset;
      r_q     <= RReset;
      scale_q <= ScaleReset;
      range_q <= RangeReset;
      divl_q  <= DivLReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_Q:     q_q     <= cfg_data_i;
        CFG_R:     r_q     <= cfg_data_i;
        CFG_SCALE: scale_q <= cfg_data_i[15:0];
        CFG_RANGE: range_q <= cfg_data_i[15:0];
        CFG_DIVL:  divl_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      est_q   <= '0;
      cov_q   <= CovReset;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && in_acc && !reject) begin
        if (diverge) begin
          est_q  <= '0;
          cov_q  <= CovReset;
          fill_q <= FillW'(1);
        end else if (fill_q != FillW'(RING_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (state_q == ST_SORT || state_q == ST_SUM) begin
        cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
      end
      if (state_q == ST_UPD2) begin
        est_q <= up_q ? est_q + mag[23:0] : est_q - mag[23:0];
      end
      if (state_q == ST_UPD3) begin
        cov_q <= 32'((cprod_q + 49'd32768) >> 16);
      end
      if (state_q == ST_OUT && out_free) begin
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Datapath payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      acc_q <= !reject;
      wr_q  <= !reject && diverge;
      p_q   <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
      if (!reject) begin
        ring_q[0] <= raw_depth_i;
        for (int i = 1; i < RING_DEPTH; i++) ring_q[i] <= ring_q[i-1];
      end
    end
    if (state_q == ST_LOAD) sum_q <= '0;
    if (state_q == ST_SUM && cvld[0] && cnt_q >= lo && cnt_q <= hi) begin
      sum_q <= sum_q + SumW'(cval[0]);
    end
    if (state_q == ST_WAIT) begin
      k_q    <= (den == 33'd0) ? 17'd0 : gquo[16:0];
      mean_q <= mquo[23:0];
    end
    if (state_q == ST_UPD1) begin
      up_q   <= (mean_q >= est_q);
      prod_q <= k_q * ((mean_q >= est_q) ? mean_q - est_q : est_q - mean_q);
    end
    if (state_q == ST_UPD2) cprod_q <= (17'd65536 - k_q) * p_q;
    if (state_q == ST_SCALE) sprod_q <= est_q * scale_q;
    if (state_q == ST_OUT && out_free) begin
      dout_q <= (sshift > 20'd65535) ? 16'hFFFF : sshift[15:0];
      oacc_q <= acc_q;
      owr_q  <= wr_q;
    end
  end

  assign out_valid_o = ov_q;
  assign depth_out_o = dout_q;
  assign accepted_o  = oacc_q;
  assign was_reset_o = owr_q;

endmodule

// ===== sv/dikf_checker.sv =====
`include "depth_iqm_kalman_filter_macros.svh"

module dikf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_idx_i,
  input logic [31:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [15:0] raw_depth_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] depth_out_o,
  input logic        accepted_o,
  input logic        was_reset_o
);

  `DIKF_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled item dropped")
  `DIKF_ASSERT(a_rej_flag, out_valid_o && !accepted_o |-> !was_reset_o, "reset on rejected item")
  `DIKF_ASSERT(a_busy, in_valid_i && !in_stall_o |=> in_stall_o, "second item taken while busy")
  `DIKF_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

bind depth_iqm_kalman_filter dikf_checker u_dikf_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
  import dikf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 200;
  localparam int WatchLimit  = 20000;

  typedef struct packed {
    logic [15:0] depth;
    logic        acc;
    logic        rst;
  } depth_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] raw_depth_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] depth_out_o;
  logic        accepted_o;
  logic        was_reset_o;

  depth_iqm_kalman_filter u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the filter
  logic [31:0] q_reg, r_reg;
  logic [15:0] scale_reg, range_reg, divl_reg;
  logic [15:0] ring [RingDepth];
  int unsigned head, fill;
  logic [23:0] est;
  logic [31:0] cov;

  depth_res_t  expected_q [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          results_seen = 0;
  int          snd_idle = 0, rcv_idle = 0;
  bit          timed_out = 0;

  function automatic logic [15:0] scaled_depth();
    logic [63:0] v;
    v = ({40'd0, est} * {48'd0, scale_reg} + 64'd524288) >> 20;
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [31:0] interquartile_mean();
    logic [15:0] srt [RingDepth];
    logic [15:0] v;
    logic [63:0] sum;
    int unsigned lo, hi, cnt, j;
    sum = 0;
    for (int i = 0; i < fill; i++) begin
      v = ring[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    lo = fill / 4;
    hi = (fill * 3) / 4;
    cnt = hi - lo + 1;
    for (int i = lo; i <= hi; i++) sum += srt[i];
    return 32'(((sum << 8) + cnt / 2) / cnt);
  endfunction

  function automatic depth_res_t filter_step(logic [15:0] raw);
    depth_res_t  res;
    logic [31:0] rawq, gap, mean, k, mag;
    logic [63:0] p, den;
    res.rst = 1'b0;
    if (raw == 0 || raw > range_reg) begin
      res.depth = scaled_depth();
      res.acc = 1'b0;
      return res;
    end
    rawq = {8'd0, raw, 8'd0};
    if (est != 0) begin
      gap = (rawq > est) ? rawq - est : est - rawq;
      if (gap > {8'd0, divl_reg, 8'd0}) begin
        est = '0; cov = CovReset; head = 0; fill = 0; res.rst = 1'b1;
      end
    end
    ring[head] = raw;
    head = (head + 1) % RingDepth;
    if (fill < RingDepth) fill++;
    mean = interquartile_mean();
    p = {32'd0, cov} + {32'd0, q_reg};
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    den = p + {32'd0, r_reg};
    k = (den == 0) ? 32'd0 : 32'((p << 16) / den);
    if (mean >= est) begin
      mag = 32'(({32'd0, k} * (mean - est) + 64'd32768) >> 16);
      est = 24'(est + mag);
    end else begin
      mag = 32'(({32'd0, k} * (est - mean) + 64'd32768) >> 16);
      est = 24'(est - mag);
    end
    cov = 32'(((64'd65536 - k) * p + 64'd32768) >> 16);
    res.depth = scaled_depth();
    res.acc = 1'b1;
    return res;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_Q:     q_reg = val;
      CFG_R:     r_reg = val;
      CFG_SCALE: scale_reg = val[15:0];
      CFG_RANGE: range_reg = val[15:0];
      CFG_DIVL:  divl_reg = val[15:0];
      default: ;
    endcase
  endtask

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_sample(logic [15:0] raw);
    while ($urandom_range(99) < snd_idle) @(negedge clk_i);
    in_valid_i <= 1'b1;
    raw_depth_i <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(filter_step(raw));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // the block stays busy here, so the next item loses nothing
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0 && !timed_out) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < rcv_idle);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      depth_res_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: depth %0d", depth_out_o);
      end else begin
        exp_r = expected_q.pop_front();
        results_seen++;
        if (exp_r.depth !== depth_out_o || exp_r.acc !== accepted_o ||
            exp_r.rst !== was_reset_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp depth %0d acc %0b rst %0b, got %0d %0b %0b",
                     exp_r.depth, exp_r.acc, exp_r.rst,
                     depth_out_o, accepted_o, was_reset_o);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [15:0] near_sample();
    int v;
    v = int'(est >> 8) + $signed($urandom_range(400)) - 200;
    if (v < 1) v = 1;
    if (v > range_reg) v = range_reg;
    return 16'(v);
  endfunction

  task automatic test_directed();
    send_sample(16'd0);
    send_sample(16'd16000);
    send_sample(16'd16010);
    send_sample(16'd15990);
    send_sample(16'd56000);
    send_sample(16'd56001);
    send_sample(16'hFFFF);
    send_sample(16'd1);
    send_sample(16'd40000);
    for (int i = 0; i < 10; i++) send_sample(16'd20000 + 16'(i * 37));
    send_sample(16'd0);
    send_sample(16'h5555);
    send_sample(16'h2AAA);
  endtask

  task automatic test_configs();
    wait_drained();
    write_reg(CFG_Q, 32'd0);
    write_reg(CFG_R, 32'd0);
    write_reg(CFG_RANGE, 16'hFFFF);
    write_reg(CFG_DIVL, 16'hFFFF);
    write_reg(CFG_SCALE, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_sample(16'(8000 + i));
    send_sample(16'hFFFF);
    wait_drained();
    write_reg(CFG_Q, 32'hFFFF_FFFF);
    write_reg(CFG_R, 32'hFFFF_FFFF);
    write_reg(CFG_DIVL, 16'd0);
    write_reg(CFG_SCALE, 16'd0);
    for (int i = 0; i < 6; i++) send_sample(16'($urandom_range(1, 65535)));
    wait_drained();
    write_reg(CFG_Q, 32'd1);
    write_reg(CFG_R, 32'd1);
    write_reg(CFG_RANGE, 16'd0);
    write_reg(CFG_SCALE, 16'd4096);
    send_sample(16'd1);
    send_sample(16'd0);
    wait_drained();
  endtask

  task automatic random_phase(int count);
    logic [15:0] raw;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        wait_drained();
        write_reg(CFG_Q, $urandom_range(1, 8) == 1 ? $urandom : $urandom_range(0, 4000));
        write_reg(CFG_R, $urandom_range(1, 8) == 1 ? $urandom : $urandom_range(1, 600000));
        write_reg(CFG_SCALE, $urandom_range(0, 65535));
        write_reg(CFG_RANGE, $urandom_range(20000, 65535));
        write_reg(CFG_DIVL, $urandom_range(500, 65535));
      end
      case ($urandom_range(9))
        0:       raw = 16'($urandom);
        1:       raw = 16'd0;
        default: raw = near_sample();
      endcase
      send_sample(raw);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    q_reg = QReset; r_reg = RReset; scale_reg = ScaleReset;
    range_reg = RangeReset; divl_reg = DivLReset;
    est = '0; cov = CovReset; head = 0; fill = 0;
    foreach (ring[i]) ring[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_configs();
    snd_idle = 6; rcv_idle = 77;
    random_phase(580);
    snd_idle = 77; rcv_idle = 6;
    random_phase(580);
    snd_idle = 0; rcv_idle = 0;
    random_phase(580);
    wait_drained();
    $display("covered reset defaults, register extremes, rejects, divergence resets");
    $display("and %0d results checked under three idling mixes", results_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
